### rtl/smwe_pkg.sv
`timescale 1ns / 1ps
package smwe_pkg;
    localparam int CMD_W = 5;
    localparam int VAL_W = 32;
    localparam int KIND_W = 2;
    localparam int ERR_W = 3;
    localparam int DEPTH_W = 7;

    localparam logic [CMD_W-1:0] C_PRINT = 5'd0, C_PUTC = 5'd1, C_DUP = 5'd2, C_POP = 5'd3,
        C_SWAP = 5'd4, C_INPUT = 5'd5, C_GETC = 5'd6, C_TOP = 5'd7, C_GRAB = 5'd8,
        C_PLACE = 5'd9, C_DSWAP = 5'd10, C_ADD = 5'd11, C_SUB = 5'd12, C_MUL = 5'd13,
        C_DIV = 5'd14, C_MOD = 5'd15, C_BOOL = 5'd16, C_AND = 5'd17, C_OR = 5'd18,
        C_XOR = 5'd19, C_NOT = 5'd20, C_SHL = 5'd21, C_SHR = 5'd22, C_EQ = 5'd23,
        C_GT = 5'd24, C_LT = 5'd25, C_GE = 5'd26, C_LE = 5'd27, C_POKE = 5'd28,
        C_PEEK = 5'd29, C_NOP0 = 5'd30, C_NOP1 = 5'd31;

    localparam logic [ERR_W-1:0] E_OK = 3'd0, E_INDEX = 3'd1, E_DIVZ = 3'd2,
        E_UNDER = 3'd3, E_OVER = 3'd4;
    localparam logic [KIND_W-1:0] K_NONE = 2'd0, K_NUM = 2'd1, K_CHAR = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [KIND_W-1:0]       out_kind;
        logic [ERR_W-1:0]        error_code;
        logic [DEPTH_W-1:0]      stack_depth;
    } t_out_item;

    function automatic logic [1:0] pops_needed(input logic [CMD_W-1:0] c);
        case (c)
            C_PRINT, C_PUTC, C_DUP, C_POP, C_GRAB, C_BOOL, C_NOT, C_PEEK: return 2'd1;
            C_INPUT, C_GETC, C_TOP, C_NOP0, C_NOP1: return 2'd0;
            default: return 2'd2;
        endcase
    endfunction

    function automatic logic grows(input logic [CMD_W-1:0] c);
        return (c == C_DUP) || (c == C_INPUT) || (c == C_GETC) || (c == C_TOP);
    endfunction
endpackage

### rtl/smwe_ram.sv
`timescale 1ns / 1ps
module smwe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/smwe_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, on magnitudes.
module smwe_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, r_den;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem[W-1:0], r_quo[W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_trial[W]) begin
                    r_rem <= {r_rem[W-1:0], r_quo[W-1]};
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
    assign o_rem = r_rem[W-1:0];
endmodule

### rtl/stack_machine_word_executor.sv
`timescale 1ns / 1ps
// Channel  | signals                         | direction
// command  | i_start, o_busy, i_cmd          | in
// result   | o_done (strobe), o_result       | out
//
// One item runs as a short sequence over the stack RAM, which has one write
// port and one registered read port: reads of the top entries and of any
// indexed entries, then up to two write-backs. Stack errors go straight to
// the result strobe; div and mod also wait on the divider.
// Byte memory: cleared by a pass over all MEM_BYTES after reset, during
// which o_busy is high. Reset is synchronous, active low; the result strobe
// lasts one cycle and cannot be stalled.
module stack_machine_word_executor
    import smwe_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_WIDTH = 32,
    parameter int MEM_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_cmd,
    output logic      o_busy,
    output logic      o_done,
    output t_out_item o_result
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int BW = $clog2(MEM_BYTES);
    localparam int SHW = $clog2(WORD_WIDTH);
    localparam int W = WORD_WIDTH;

    // sequencer states
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RDA = 4'd2, S_RDB = 4'd3,
        S_EXEC = 4'd4, S_RDX = 4'd5, S_RDY = 4'd6, S_WR2 = 4'd7, S_DIV = 4'd8,
        S_BYTE = 4'd9, S_DONE = 4'd10;

    logic [3:0]     r_state, n_state;
    logic [SPW-1:0] r_sp, n_sp;
    logic [CMD_W-1:0] r_cmd;
    logic [W-1:0]   r_inv, r_a, r_b, r_x, n_a, n_b, n_x;
    logic [W-1:0]   r_val, n_val;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ERR_W-1:0]  r_err, n_err;
    logic [BW-1:0]  r_clr;
    logic           n_done;

    // stack RAM port
    logic           s_we;
    logic [AW-1:0]  s_wa, s_ra;
    logic [W-1:0]   s_wd, s_rd;
    // byte RAM port
    logic           b_we;
    logic [BW-1:0]  b_wa, b_ra;
    logic [7:0]     b_wd, b_rd;

    smwe_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    smwe_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_bytes (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd),
        .i_raddr(b_ra), .o_rdata(b_rd));

    // divider on magnitudes, top / second
    logic         d_start, d_done;
    logic [W-1:0] d_quo, d_rem, a_mag, b_mag;
    logic         a_neg, b_neg;
    assign a_neg = r_a[W-1];
    assign b_neg = r_b[W-1];
    assign a_mag = a_neg ? (~r_a + 1'b1) : r_a;
    assign b_mag = b_neg ? (~r_b + 1'b1) : r_b;
    smwe_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(a_mag), .i_den(b_mag), .o_done(d_done), .o_quo(d_quo), .o_rem(d_rem));

    logic [W-1:0] prod;
    assign prod = r_a * r_b;   // one multiplier, registered operands

    // helpers
    logic [SPW-1:0] sp1, sp2;
    logic [SHW-1:0] sh;
    logic signed [W-1:0] sa, sb;
    logic [W-1:0] alu;
    logic         has_alu;
    logic [W-1:0] sp_w;
    assign sp1 = r_sp - SPW'(1);
    assign sp2 = r_sp - SPW'(2);
    assign sh = r_b[SHW-1:0];
    assign sa = r_a;
    assign sb = r_b;
    assign sp_w = W'(r_sp);

    always_comb begin
        has_alu = 1'b1;
        case (r_cmd)
            C_ADD: alu = r_a + r_b;
            C_SUB: alu = r_a - r_b;
            C_MUL: alu = prod;
            C_AND: alu = r_a & r_b;
            C_OR:  alu = r_a | r_b;
            C_XOR: alu = r_a ^ r_b;
            C_SHL: alu = r_a << sh;
            C_SHR: alu = W'(sa >>> sh);
            C_EQ:  alu = {W{r_a == r_b}};
            C_GT:  alu = {W{sa > sb}};
            C_LT:  alu = {W{sa < sb}};
            C_GE:  alu = {W{sa >= sb}};
            C_LE:  alu = {W{sa <= sb}};
            C_BOOL: alu = {W{r_a != '0}};
            C_NOT: alu = ~r_a;
            default: begin
                alu = '0;
                has_alu = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sp = r_sp;
        n_a = r_a;
        n_b = r_b;
        n_x = r_x;
        n_val = r_val;
        n_kind = r_kind;
        n_err = r_err;
        n_done = 1'b0;
        s_we = 1'b0;
        s_wa = sp1[AW-1:0];
        s_wd = r_a;
        s_ra = sp1[AW-1:0];
        b_we = 1'b0;
        b_wa = r_b[BW-1:0];
        b_wd = r_a[7:0];
        b_ra = r_a[BW-1:0];
        d_start = 1'b0;
        case (r_state)
            S_CLR: begin
                b_we = 1'b1;
                b_wa = r_clr;
                b_wd = 8'd0;
                if (r_clr == BW'(MEM_BYTES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_val = '0;
                    n_kind = K_NONE;
                    n_err = E_OK;
                    if (r_sp < SPW'(pops_needed(i_cmd.cmd))) begin
                        n_err = E_UNDER;
                        n_state = S_DONE;
                    end else if (grows(i_cmd.cmd) && r_sp == SPW'(STACK_DEPTH)) begin
                        n_err = E_OVER;
                        n_state = S_DONE;
                    end else if (pops_needed(i_cmd.cmd) != 2'd0) begin
                        n_state = S_RDA;   // read of top issued now
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_RDA: begin
                n_a = s_rd;
                s_ra = sp2[AW-1:0];
                n_state = (pops_needed(r_cmd) == 2'd2) ? S_RDB : S_EXEC;
            end
            S_RDB: begin
                n_b = s_rd;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    C_PRINT: begin
                        n_sp = sp1; n_val = r_a; n_kind = K_NUM;
                    end
                    C_PUTC: begin
                        n_sp = sp1; n_val = W'(r_a[7:0]); n_kind = K_CHAR;
                    end
                    C_POP: n_sp = sp1;
                    C_DUP: begin
                        s_we = 1'b1; s_wa = r_sp[AW-1:0]; n_sp = r_sp + 1'b1;
                    end
                    C_INPUT: begin
                        s_we = 1'b1; s_wa = r_sp[AW-1:0]; s_wd = W'(r_inv);
                        n_sp = r_sp + 1'b1;
                    end
                    C_GETC: begin
                        s_we = 1'b1; s_wa = r_sp[AW-1:0];
                        s_wd = {{(W-8){r_inv[7]}}, r_inv[7:0]};
                        n_sp = r_sp + 1'b1;
                    end
                    C_TOP: begin
                        s_we = 1'b1; s_wa = r_sp[AW-1:0]; s_wd = sp_w;
                        n_sp = r_sp + 1'b1;
                    end
                    C_SWAP: begin
                        s_we = 1'b1; s_wa = sp2[AW-1:0]; s_wd = r_a;
                        n_x = r_b; n_state = S_WR2;
                    end
                    C_GRAB: begin
                        n_sp = sp1;
                        if (r_a >= W'(sp1)) begin
                            n_err = E_INDEX;
                        end else begin
                            s_ra = AW'(sp1 - SPW'(r_a) - SPW'(1));
                            n_state = S_RDX;
                        end
                    end
                    C_PLACE: begin
                        n_sp = sp2;
                        if (r_b >= W'(sp2)) begin
                            n_err = E_INDEX;
                        end else begin
                            s_we = 1'b1;
                            s_wa = AW'(sp2 - SPW'(r_b) - SPW'(1));
                        end
                    end
                    C_DSWAP: begin
                        n_sp = sp2;
                        if (r_a >= W'(sp2) || r_b >= W'(sp2)) begin
                            n_err = E_INDEX;
                        end else begin
                            s_ra = AW'(sp2 - SPW'(r_a) - SPW'(1));
                            n_state = S_RDX;
                        end
                    end
                    C_DIV, C_MOD: begin
                        n_sp = sp2;
                        if (r_b == '0) begin
                            n_err = E_DIVZ;
                        end else begin
                            d_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    C_POKE: begin
                        n_sp = sp2; b_we = 1'b1;
                    end
                    C_PEEK: n_state = S_BYTE;
                    C_NOP0, C_NOP1: ;
                    default: begin
                        if (has_alu) begin
                            s_we = 1'b1;
                            s_wd = alu;
                            if (pops_needed(r_cmd) == 2'd2) begin
                                s_wa = sp2[AW-1:0]; n_sp = sp1;
                            end
                        end
                    end
                endcase
            end
            S_RDX: begin
                if (r_cmd == C_GRAB) begin
                    // r_sp already reduced by one
                    s_we = 1'b1; s_wa = r_sp[AW-1:0]; s_wd = s_rd;
                    n_sp = r_sp + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_x = s_rd;
                    s_ra = AW'(r_sp - SPW'(r_b) - SPW'(1));
                    n_state = S_RDY;
                end
            end
            S_RDY: begin
                // entry b -> slot a, then held entry a -> slot b
                s_we = 1'b1; s_wa = AW'(r_sp - SPW'(r_a) - SPW'(1)); s_wd = s_rd;
                n_state = S_WR2;
            end
            S_WR2: begin
                s_we = 1'b1; s_wd = r_x;
                s_wa = (r_cmd == C_SWAP) ? sp1[AW-1:0]
                                         : AW'(r_sp - SPW'(r_b) - SPW'(1));
                n_state = S_DONE;
            end
            S_DIV: begin
                if (d_done) begin
                    s_we = 1'b1; s_wa = r_sp[AW-1:0]; n_sp = r_sp + 1'b1;
                    if (r_cmd == C_DIV) s_wd = (a_neg != b_neg) ? (~d_quo + 1'b1) : d_quo;
                    else s_wd = a_neg ? (~d_rem + 1'b1) : d_rem;
                    n_state = S_DONE;
                end
            end
            S_BYTE: begin
                s_we = 1'b1; s_wd = W'(b_rd);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_sp <= '0;
            r_clr <= '0;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp <= n_sp;
            o_done <= n_done;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_cmd.cmd;
            r_inv <= W'(i_cmd.in_value);   // sign-extended to the word
        end
        r_a <= n_a;
        r_b <= n_b;
        r_x <= n_x;
        r_val <= n_val;
        r_kind <= n_kind;
        r_err <= n_err;
        if (n_done) begin
            o_result.out_value <= VAL_W'(r_val);
            o_result.out_kind <= r_kind;
            o_result.error_code <= r_err;
            o_result.stack_depth <= DEPTH_W'(r_sp);
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

### rtl/smwe_checker.sv
`timescale 1ns / 1ps
module smwe_checker
    import smwe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_done,
    input t_out_item o_result
);
    a_no_done_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_done) else $error("result too early");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double strobe");
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out_kind != 2'd3)) else $error("bad kind");
    a_err_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error_code != E_OK) |-> (o_result.out_kind == K_NONE))
        else $error("emit on error");
endmodule

bind stack_machine_word_executor smwe_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_result(o_result));

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import smwe_pkg::*;

    localparam int N_RANDOM = 612;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_cmd;
    logic      o_busy;
    logic      o_done;
    t_out_item o_result;

    stack_machine_word_executor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Machine state mirrored by the predictor
    logic [31:0] shadow_stack [64];
    int unsigned shadow_sp;
    logic [7:0]  shadow_mem [256];

    t_out_item   pending_results [$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int          sender_idle_pct;

    function automatic int unsigned pops_for(logic [4:0] c);
        case (c)
            C_PRINT, C_PUTC, C_DUP, C_POP, C_GRAB, C_BOOL, C_NOT, C_PEEK: return 1;
            C_INPUT, C_GETC, C_TOP, C_NOP0, C_NOP1: return 0;
            default: return 2;
        endcase
    endfunction

    function automatic logic [31:0] all_ones_if(logic c);
        return c ? '1 : '0;
    endfunction

    // Works out the result of one word and updates the shadow state.
    function automatic t_out_item execute_word(t_in_item it);
        t_out_item   res;
        logic [31:0] a, b, r, ma, mb, q, rm, tmp;
        logic        grows_stack;
        int unsigned i1, i2;
        res = '0;
        grows_stack = (it.cmd == C_DUP) || (it.cmd == C_INPUT) ||
                      (it.cmd == C_GETC) || (it.cmd == C_TOP);
        if (shadow_sp < pops_for(it.cmd)) begin
            res.error_code = E_UNDER;
        end else if (grows_stack && shadow_sp + 1 > 64) begin
            res.error_code = E_OVER;
        end else begin
            res.error_code = E_OK;
            if (pops_for(it.cmd) >= 1) begin
                shadow_sp--;
                a = shadow_stack[shadow_sp];
            end
            if (pops_for(it.cmd) == 2) begin
                shadow_sp--;
                b = shadow_stack[shadow_sp];
            end
            case (it.cmd)
                C_PRINT: begin
                    res.out_value = a;
                    res.out_kind = K_NUM;
                end
                C_PUTC: begin
                    res.out_value = {24'd0, a[7:0]};
                    res.out_kind = K_CHAR;
                end
                C_DUP: begin
                    shadow_stack[shadow_sp] = a;
                    shadow_stack[shadow_sp + 1] = a;
                    shadow_sp += 2;
                end
                C_POP: ;
                C_SWAP: begin
                    shadow_stack[shadow_sp] = a;
                    shadow_stack[shadow_sp + 1] = b;
                    shadow_sp += 2;
                end
                C_INPUT: begin
                    shadow_stack[shadow_sp] = it.in_value;
                    shadow_sp++;
                end
                C_GETC: begin
                    shadow_stack[shadow_sp] = {{24{it.in_value[7]}}, it.in_value[7:0]};
                    shadow_sp++;
                end
                C_TOP: begin
                    shadow_stack[shadow_sp] = shadow_sp;
                    shadow_sp++;
                end
                C_GRAB: begin
                    if (a >= shadow_sp) begin
                        res.error_code = E_INDEX;
                    end else begin
                        shadow_stack[shadow_sp] = shadow_stack[shadow_sp - a - 1];
                        shadow_sp++;
                    end
                end
                C_PLACE: begin
                    if (b >= shadow_sp) res.error_code = E_INDEX;
                    else shadow_stack[shadow_sp - b - 1] = a;
                end
                C_DSWAP: begin
                    if (a >= shadow_sp || b >= shadow_sp) begin
                        res.error_code = E_INDEX;
                    end else begin
                        i1 = shadow_sp - a - 1;
                        i2 = shadow_sp - b - 1;
                        tmp = shadow_stack[i1];
                        shadow_stack[i1] = shadow_stack[i2];
                        shadow_stack[i2] = tmp;
                    end
                end
                C_DIV, C_MOD: begin
                    if (b == 0) begin
                        res.error_code = E_DIVZ;
                    end else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        rm = ma % mb;
                        if (it.cmd == C_DIV) r = (a[31] != b[31]) ? -q : q;
                        else r = a[31] ? -rm : rm;
                        shadow_stack[shadow_sp] = r;
                        shadow_sp++;
                    end
                end
                C_BOOL, C_NOT: begin
                    shadow_stack[shadow_sp] = (it.cmd == C_NOT) ? ~a : all_ones_if(a != 0);
                    shadow_sp++;
                end
                C_POKE: shadow_mem[b[7:0]] = a[7:0];
                C_PEEK: begin
                    shadow_stack[shadow_sp] = {24'd0, shadow_mem[a[7:0]]};
                    shadow_sp++;
                end
                C_NOP0, C_NOP1: ;
                default: begin
                    case (it.cmd)
                        C_ADD: r = a + b;
                        C_SUB: r = a - b;
                        C_MUL: r = a * b;
                        C_AND: r = a & b;
                        C_OR:  r = a | b;
                        C_XOR: r = a ^ b;
                        C_SHL: r = a << b[4:0];
                        C_SHR: r = $signed(a) >>> b[4:0];
                        C_EQ:  r = all_ones_if(a == b);
                        C_GT:  r = all_ones_if($signed(a) > $signed(b));
                        C_LT:  r = all_ones_if($signed(a) < $signed(b));
                        C_GE:  r = all_ones_if($signed(a) >= $signed(b));
                        default: r = all_ones_if($signed(a) <= $signed(b));
                    endcase
                    shadow_stack[shadow_sp] = r;
                    shadow_sp++;
                end
            endcase
        end
        res.stack_depth = shadow_sp[6:0];
        return res;
    endfunction

    // Result checking; the block cannot be stalled, so every strobe is taken.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.out_value !== want.out_value ||
                    o_result.out_kind !== want.out_kind ||
                    o_result.error_code !== want.error_code ||
                    o_result.stack_depth !== want.stack_depth) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h got %h", want, o_result);
                end
            end
        end
    end

    // Watchdog: cycles with no item accepted in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Hands one item to the block; the expectation is queued at acceptance.
    // start stays high after acceptance until the next idle or the end of a run.
    task automatic send_word(input t_in_item it, input logic check_fixed,
                             input t_out_item fixed);
        t_out_item want;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        want = execute_word(it);
        // typed-in values must also agree with the predictor
        if (check_fixed && want !== fixed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("directed row disagrees: table %h predictor %h", fixed, want);
        end
        pending_results.push_back(want);
    endtask

    function automatic t_in_item mk(logic [4:0] c, logic [31:0] v);
        t_in_item it;
        it.cmd = c;
        it.in_value = v;
        return it;
    endfunction

    function automatic t_out_item ex(logic [31:0] v, logic [1:0] k,
                                     logic [2:0] e, logic [6:0] d);
        t_out_item r;
        r.out_value = v;
        r.out_kind = k;
        r.error_code = e;
        r.stack_depth = d;
        return r;
    endfunction

    typedef struct {
        t_in_item  word;
        logic      fixed;
        t_out_item result;
    } t_row;

    // Random word: small indices, extremes or random values; pushes while shallow, pops near full
    function automatic t_in_item random_word();
        logic [31:0] v;
        logic [4:0]  c;
        case ($urandom_range(5))
            0: v = $urandom_range(3);
            1: v = $urandom_range(31);
            2: v = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
            3: v = $urandom_range(1) ? 32'hffff_ffff : 32'd0;
            default: v = $urandom;
        endcase
        if (shadow_sp < 4 || (shadow_sp < 60 && $urandom_range(2) == 0))
            c = C_INPUT;
        else if (shadow_sp > 58 && $urandom_range(1))
            c = $urandom_range(1) ? C_POP : C_PRINT;
        else
            c = $urandom_range(31);
        return mk(c, v);
    endfunction

    initial begin
        t_row rows [$];
        int   phase;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        sender_idle_pct = 0;
        shadow_sp = 0;
        foreach (shadow_mem[k]) shadow_mem[k] = '0;
        foreach (shadow_stack[k]) shadow_stack[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty-stack errors, extremes, divide special cases, an index error, poke/peek
        rows.push_back('{mk(C_PRINT, 0), 1, ex(0, K_NONE, E_UNDER, 0)});
        rows.push_back('{mk(C_ADD, 0), 1, ex(0, K_NONE, E_UNDER, 0)});
        rows.push_back('{mk(C_NOP0, 0), 1, ex(0, K_NONE, E_OK, 0)});
        rows.push_back('{mk(C_TOP, 0), 1, ex(0, K_NONE, E_OK, 1)});
        rows.push_back('{mk(C_PRINT, 0), 1, ex(0, K_NUM, E_OK, 0)});
        rows.push_back('{mk(C_GETC, 32'h0000_0080), 1, ex(0, K_NONE, E_OK, 1)});
        rows.push_back('{mk(C_PUTC, 0), 1, ex(32'h80, K_CHAR, E_OK, 0)});
        rows.push_back('{mk(C_INPUT, 0), 0, '0});
        rows.push_back('{mk(C_INPUT, 5), 0, '0});
        rows.push_back('{mk(C_DIV, 0), 1, ex(0, K_NONE, E_DIVZ, 0)});
        rows.push_back('{mk(C_INPUT, 32'hffff_ffff), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'h8000_0000), 0, '0});
        rows.push_back('{mk(C_DIV, 0), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'hffff_ffff), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'h8000_0000), 0, '0});
        rows.push_back('{mk(C_MOD, 0), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'd1000), 0, '0});
        rows.push_back('{mk(C_GRAB, 0), 1, ex(0, K_NONE, E_INDEX, 2)});
        rows.push_back('{mk(C_INPUT, 32'h7fff_ffff), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'h0000_01ff), 0, '0});
        rows.push_back('{mk(C_POKE, 0), 0, '0});
        rows.push_back('{mk(C_INPUT, 32'h0000_01ff), 0, '0});
        rows.push_back('{mk(C_PEEK, 0), 0, '0});
        rows.push_back('{mk(C_PRINT, 0), 0, '0});
        foreach (rows[k]) send_word(rows[k].word, rows[k].fixed, rows[k].result);

        // Fill to the top so overflow is seen
        while (shadow_sp < 64) send_word(mk(C_INPUT, $urandom), 0, '0);
        send_word(mk(C_TOP, 0), 1, ex(0, K_NONE, E_OVER, 64));
        send_word(mk(C_DUP, 0), 1, ex(0, K_NONE, E_OVER, 64));
        i_start <= 1'b0;

        // Pause until every outstanding result has come back
        wait (pending_results.size() == 0);
        @(posedge i_clk);

        for (phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 66 : 0;
            repeat (N_RANDOM / 3) send_word(random_word(), 0, '0);
        end
        i_start <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
rtl/smwe_pkg.sv
rtl/smwe_ram.sv
rtl/smwe_div.sv
rtl/stack_machine_word_executor.sv
rtl/smwe_checker.sv
tb/testbench.sv
